@@ rtl/core/rdf_pkg.sv @@
`default_nettype none

package rdf_pkg;

  localparam int unsigned INT_BITS    = 32;
  localparam int unsigned FRAC_BITS   = 32;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BASE_W      = 5;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned FRAC_DIGITS_DEF = 3;

  localparam int unsigned STACK_DEPTH = INT_BITS;
  localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Quotient bits resolved per cycle by the shift-subtract divider.
  localparam int unsigned DIV_STEPS   = 8;
  localparam int unsigned DIV_CYCLES  = INT_BITS / DIV_STEPS;
  localparam int unsigned DIV_CNT_W   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_NUL      = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_DOT      = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_A = 7'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

  typedef struct packed {
    logic [INT_BITS-1:0]  int_part;
    logic [FRAC_BITS-1:0] frac_part;
    logic [BASE_W-1:0]    base;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_base;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP_RD,
    ST_POP,
    ST_DOT,
    ST_FRAC,
    ST_BAD
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_DIGIT,
    EMIT_DOT,
    EMIT_FRAC,
    EMIT_BAD
  } emit_e;

  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  pop_rd;
    emit_e emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic div_end;
    logic stack_empty;
    logic out_free;
    logic frac_last;
  } ctl_status_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LETTER_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rdf_ram.sv @@
`default_nettype none

module rdf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rdf_ctrl.sv @@
`default_nettype none

module rdf_ctrl
  import rdf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ctl_status_t status_i,
  output ctl_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_bad ? ST_BAD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_end) begin
          state_d = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        state_d = ST_POP;
      end
      ST_POP: begin
        if (status_i.out_free) begin
          state_d = status_i.stack_empty ? ST_DOT : ST_POP_RD;
        end
      end
      ST_DOT: begin
        if (status_i.out_free) begin
          state_d = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (status_i.out_free && status_i.frac_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_BAD: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '{load: 1'b0, div_step: 1'b0, pop_rd: 1'b0, emit: EMIT_NONE};
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      ST_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
      end
      ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_DIGIT;
        end
      end
      ST_DOT: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_DOT;
        end
      end
      ST_FRAC: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_FRAC;
        end
      end
      ST_BAD: begin
        if (status_i.out_free) begin
          cmd_o.emit = EMIT_BAD;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rdf_datapath.sv @@
`default_nettype none

module rdf_datapath
  import rdf_pkg::*;
#(
  parameter int unsigned FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_t      in_data_i,
  input  wire ctl_cmd_t cmd_i,
  output ctl_status_t   status_o,
  output logic          out_valid_o,
  output out_t          out_data_o,
  input  wire logic     out_stall_i
);

  localparam int unsigned FCNT_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

  logic [INT_BITS-1:0]  quo_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [BASE_W-1:0]    base_q;
  logic [DIGIT_W-1:0]   rem_q;
  logic [DIV_CNT_W-1:0] chunk_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [FCNT_W-1:0]    fcnt_q;
  logic                 out_valid_q;
  out_t                 out_q;

  logic [INT_BITS-1:0]         div_quo;
  logic [DIGIT_W-1:0]          div_rem;
  logic                        div_last;
  logic [CNT_W-1:0]            cnt_dec;
  logic [FRAC_BITS+BASE_W-1:0] frac_prod;
  logic [DIGIT_W-1:0]          frac_digit;
  logic [DIGIT_W-1:0]          stack_rdata;
  logic                        stack_we;
  logic                        out_free;

  // Restoring division by the base, several quotient bits per cycle.
  always_comb begin
    logic [DIGIT_W:0]    t;
    logic [DIGIT_W-1:0]  r;
    logic [INT_BITS-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, q[INT_BITS-1]};
      q = {q[INT_BITS-2:0], 1'b0};
      if (t >= base_q) begin
        t    = t - base_q;
        q[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    div_quo = q;
    div_rem = r;
  end

  assign div_last   = (chunk_q == DIV_CNT_W'(DIV_CYCLES - 1));
  assign stack_we   = cmd_i.div_step && div_last;
  assign cnt_dec    = cnt_q - CNT_W'(1);
  assign frac_prod  = frac_q * base_q;
  assign frac_digit = frac_prod[FRAC_BITS +: DIGIT_W];
  assign out_free   = !out_valid_q || !out_stall_i;

  rdf_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (cnt_q[STACK_AW-1:0]),
    .wdata_i (div_rem),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (cnt_dec[STACK_AW-1:0]),
    .rdata_o (stack_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q  <= in_data_i.int_part;
      frac_q <= in_data_i.frac_part;
      base_q <= in_data_i.base;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= div_quo;
      rem_q <= div_last ? '0 : div_rem;
    end else if (cmd_i.emit == EMIT_FRAC) begin
      frac_q <= frac_prod[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      cnt_q   <= '0;
      fcnt_q  <= '0;
    end else if (cmd_i.load) begin
      chunk_q <= '0;
      cnt_q   <= '0;
      fcnt_q  <= '0;
    end else begin
      if (cmd_i.div_step) begin
        chunk_q <= div_last ? '0 : chunk_q + DIV_CNT_W'(1);
      end
      if (stack_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.pop_rd) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.emit == EMIT_FRAC) begin
        fcnt_q <= fcnt_q + FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      EMIT_DIGIT: begin
        out_q <= '{char_code: glyph(stack_rdata), last_char: 1'b0, bad_base: 1'b0};
      end
      EMIT_DOT: begin
        out_q <= '{char_code: CHAR_DOT, last_char: 1'b0, bad_base: 1'b0};
      end
      EMIT_FRAC: begin
        out_q <= '{char_code: glyph(frac_digit), last_char: status_o.frac_last,
                   bad_base: 1'b0};
      end
      EMIT_BAD: begin
        out_q <= '{char_code: CHAR_NUL, last_char: 1'b1, bad_base: 1'b1};
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  assign status_o.in_bad      = (in_data_i.base < BASE_MIN) || (in_data_i.base > BASE_MAX);
  assign status_o.div_end     = div_last &&
                                ((div_quo == '0) || (cnt_q == CNT_W'(STACK_DEPTH - 1)));
  assign status_o.stack_empty = (cnt_q == '0);
  assign status_o.out_free    = out_free;
  assign status_o.frac_last   = (fcnt_q == FCNT_W'(FRAC_DIGITS - 1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("Digit count exceeds the stack depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit != EMIT_NONE) |-> out_free)
    else $error("Character emitted while the output register is occupied.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_rd |-> (cnt_q != '0))
    else $error("Stack read with no stacked digit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stack_we && !cmd_i.load) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("Digit push did not advance the digit count.");

endmodule

`default_nettype wire

@@ rtl/core/radix_digit_formatter.sv @@
`default_nettype none

// Converts a non-negative fixed-point number (32-bit integer part, 32-bit binary
// fraction) into ASCII text in a base from 2 to 16, one character per output
// transaction: the integer digits most significant first, then '.', then
// FRAC_DIGITS truncated fraction digits, the final character flagged by last_char.
// A base outside 2 to 16 yields a single transaction with char_code 0, last_char
// and bad_base set. One conversion is handled at a time. The shift-subtract
// divider resolves 8 quotient bits per cycle; each integer digit is divided out
// of the integer part and pushed onto the digit stack RAM. The digits are then
// read back from the stack RAM in states ST_POP_RD and ST_POP, the '.' follows,
// and each fraction digit is one step of the fraction-by-base multiplier. The
// next input is accepted as soon as the last character is in the output register.
module radix_digit_formatter
  import rdf_pkg::*;
#(
  parameter int unsigned FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  rdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdf_datapath #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

@@ bench/radix_digit_formatter_tb.sv @@
`timescale 1ns / 1ps

module radix_digit_formatter_tb;
  import rdf_pkg::*;

  localparam int unsigned IDLE_PCT      = 20;
  localparam int unsigned RANDOM_ITEMS  = 330;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam string       DIGIT_GLYPHS  = "0123456789ABCDEF";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  pending_numbers[$];
  out_t expected_chars[$];

  int unsigned numbers_sent = 0;
  int unsigned bad_bases_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles = 0;

  radix_digit_formatter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic out_t text_char(input logic [CHAR_W-1:0] code, input logic last);
    out_t c;
    c.char_code = code;
    c.last_char = last;
    c.bad_base  = 1'b0;
    return c;
  endfunction

  task automatic queue_rendered_chars(input in_t number);
    logic [31:0]        radix;
    logic [31:0]        quotient;
    logic [31:0]        fraction;
    logic [63:0]        product;
    logic [DIGIT_W-1:0] digits[STACK_DEPTH];
    logic [DIGIT_W-1:0] d;
    out_t               flagged;
    int                 count;
    radix = 32'(number.base);
    if (radix < 2 || radix > 16) begin
      flagged.char_code = CHAR_NUL;
      flagged.last_char = 1'b1;
      flagged.bad_base  = 1'b1;
      expected_chars.push_back(flagged);
    end else begin
      quotient = number.int_part;
      count = 0;
      do begin
        digits[count] = DIGIT_W'(quotient % radix);
        count++;
        quotient = quotient / radix;
      end while (quotient != 0 && count < STACK_DEPTH);
      for (int k = count - 1; k >= 0; k--) begin
        expected_chars.push_back(text_char(CHAR_W'(DIGIT_GLYPHS[digits[k]]), 1'b0));
      end
      expected_chars.push_back(text_char(CHAR_DOT, 1'b0));
      fraction = number.frac_part;
      for (int k = 0; k < FRAC_DIGITS_DEF; k++) begin
        product = 64'(fraction) * 64'(radix);
        d = product[35:32];
        fraction = product[31:0];
        expected_chars.push_back(text_char(CHAR_W'(DIGIT_GLYPHS[d]),
                                           k == FRAC_DIGITS_DEF - 1));
      end
    end
  endtask

  function automatic in_t make_number(input logic [31:0] ip, input logic [31:0] fp,
                                      input logic [BASE_W-1:0] b);
    in_t n;
    n.int_part  = ip;
    n.frac_part = fp;
    n.base      = b;
    return n;
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    logic [BASE_W-1:0] b;
    if ($urandom_range(99) < 10) begin
      b = BASE_W'($urandom_range(16)) + BASE_MAX + BASE_W'(1);
      if (b < BASE_MIN) begin
        b = BASE_W'($urandom_range(1));
      end
    end else begin
      b = BASE_W'($urandom_range(16, 2));
    end
    return b;
  endfunction

  wire in_accept  = in_valid && !in_stall;
  wire out_accept = out_valid && !out_stall;

  // Input driver: a held transaction stays put until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_accept) begin
        queue_rendered_chars(in_data);
        numbers_sent++;
        if (in_data.base < BASE_MIN || in_data.base > BASE_MAX) begin
          bad_bases_sent++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (pending_numbers.size() != 0 &&
            ((numbers_sent >= 120 && numbers_sent < 200) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data  <= pending_numbers.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_accept) begin
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected character: code %h last %b bad %b",
                     out_data.char_code, out_data.last_char, out_data.bad_base);
          end
        end else begin
          want = expected_chars.pop_front();
          chars_checked++;
          if (out_data.char_code !== want.char_code ||
              out_data.last_char !== want.last_char ||
              out_data.bad_base !== want.bad_base) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch on character %0d: expected code %h last %b bad %b, got code %h last %b bad %b",
                       chars_checked, want.char_code, want.last_char, want.bad_base,
                       out_data.char_code, out_data.last_char, out_data.bad_base);
            end
          end
        end
      end
      out_stall <= !(chars_checked >= 800 && chars_checked < 1600) &&
                   ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (in_accept || out_accept) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    pending_numbers.push_back(make_number(32'h0, 32'h0, 5'd2));
    pending_numbers.push_back(make_number(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd2));
    pending_numbers.push_back(make_number(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16));
    pending_numbers.push_back(make_number(32'h0, 32'h8000_0000, 5'd10));
    pending_numbers.push_back(make_number(32'd1, 32'h0, 5'd16));
    pending_numbers.push_back(make_number(32'hFFFF_FFFF, 32'h0, 5'd3));
    pending_numbers.push_back(make_number(32'd255, 32'h5555_5555, 5'd3));
    pending_numbers.push_back(make_number(32'hDEAD_BEEF, 32'hFEDC_BA98, 5'd16));
    pending_numbers.push_back(make_number(32'd1000, 32'h1999_999A, 5'd10));
    pending_numbers.push_back(make_number(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
    pending_numbers.push_back(make_number(32'd5, 32'd7, 5'd1));
    pending_numbers.push_back(make_number(32'd9, 32'd9, 5'd17));
    pending_numbers.push_back(make_number(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
    for (int b = 4; b <= 15; b++) begin
      pending_numbers.push_back(make_number($urandom, $urandom, BASE_W'(b)));
    end
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pending_numbers.push_back(make_number($urandom >> $urandom_range(31), $urandom,
                                            random_base()));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) &&
           stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      $display("converted %0d numbers, %0d of them with an unsupported base",
               numbers_sent, bad_bases_sent);
      $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule
